[rtl/core/md5sh_pkg.sv]
// Package for the MD5 stream hasher: types, initial chaining values and round tables.
`default_nettype none

package md5sh_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastPos = 6'h3f;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_FIN
  } state_e;

  // What the block store holds for the compression that is running.
  typedef enum logic [1:0] {
    K_NORMAL,
    K_PAD1,
    K_PAD2
  } blk_kind_e;

  function automatic logic [4:0] rot_amt(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/core/md5_stream_hasher.sv]
// Top level of the MD5 stream hasher: byte intake, round sequencer and digest output.
`default_nettype none

// MD5 message digest over a byte stream.
// Input channel (in_valid_i / in_ready_o) carries one optional message byte
// (byte_valid_i, data_byte_i) and an end mark (last_i). A transfer that only
// stores a byte leaves the block ready again at once.
// The 64th byte of a block starts the compression: one round per cycle on a
// single shared round unit, then the chaining add, and the block is not
// ready again until that add is done.
// A transfer with last_i set pads the message in place (the 0x80 byte, zero
// fill and bit length are formed as words are read, so no clearing sweep is
// needed) and runs one or two further compressions, then hands the digest
// to the output register.
// The output channel (out_valid_o / out_ready_i) delivers digest_a_o to
// digest_d_o from that register. A stalled receiver does not block new
// bytes: only the next finish waits until the previous digest is taken.
// After a digest is loaded, the chaining words and the bit count return to
// their initial values for the next message.
// Reset loads the MD5 initial values, clears the bit count and leaves the
// block store as it is; it is always written before it is read.
module md5_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_a_o,
  output logic [31:0] digest_b_o,
  output logic [31:0] digest_c_o,
  output logic [31:0] digest_d_o
);
  import md5sh_pkg::*;

  state_e      state_q, state_d;
  blk_kind_e   kind_q, kind_d;
  logic        fin_q, fin_d;
  logic [5:0]  rnd_q;
  logic [63:0] count_q;
  logic [31:0] ha_q, hb_q, hc_q, hd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] out_a_q, out_b_q, out_c_q, out_d_q;
  logic        out_valid_q;
  logic [7:0]  blk_q [16][4];

  logic        accept;
  logic        full_blk;
  logic        emit;
  logic [5:0]  in_pos;
  logic [5:0]  pad_pos;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;

  // Round unit signals.
  logic [3:0]  widx;
  logic [7:0]  r5, r3, r7;
  logic [31:0] fval;
  logic [31:0] mword;
  logic [31:0] rsum;
  logic [63:0] rot_w;
  logic [31:0] b_new;

  assign in_pos   = count_q[8:3];
  assign pad_pos  = count_q[8:3];
  assign accept   = in_valid_i & in_ready_o;
  assign full_blk = byte_valid_i & (in_pos == LastPos);
  assign emit     = (state_q == S_FIN) & (~out_valid_q | out_ready_i);

  assign sum_a = ha_q + a_q;
  assign sum_b = hb_q + b_q;
  assign sum_c = hc_q + c_q;
  assign sum_d = hd_q + d_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    fin_d   = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (full_blk) begin
            state_d = S_ROUND;
            kind_d  = K_NORMAL;
            fin_d   = last_i;
          end else if (last_i) begin
            state_d = S_ROUND;
            kind_d  = K_PAD1;
            fin_d   = 1'b0;
          end
        end
      end
      S_ROUND: begin
        if (rnd_q == LastPos) state_d = S_ADD;
      end
      S_ADD: begin
        if (kind_q == K_NORMAL) begin
          if (fin_q) begin
            state_d = S_ROUND;
            kind_d  = K_PAD1;
            fin_d   = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end else if (kind_q == K_PAD1 && pad_pos >= LenPos) begin
          state_d = S_ROUND;
          kind_d  = K_PAD2;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (emit) begin
          state_d = S_IDLE;
          kind_d  = K_NORMAL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = out_valid_q;
    digest_a_o  = out_a_q;
    digest_b_o  = out_b_q;
    digest_c_o  = out_c_q;
    digest_d_o  = out_d_q;
  end

  // Message word index and round function for the current round.
  always_comb begin
    r5 = 8'(rnd_q[3:0]) * 8'd5 + 8'd1;
    r3 = 8'(rnd_q[3:0]) * 8'd3 + 8'd5;
    r7 = 8'(rnd_q[3:0]) * 8'd7;
    case (rnd_q[5:4])
      2'd0:    begin widx = rnd_q[3:0]; fval = (b_q & c_q) | (~b_q & d_q); end
      2'd1:    begin widx = r5[3:0];    fval = (b_q & d_q) | (c_q & ~d_q); end
      2'd2:    begin widx = r3[3:0];    fval = b_q ^ c_q ^ d_q;           end
      default: begin widx = r7[3:0];    fval = c_q ^ (b_q | ~d_q);        end
    endcase
  end

  // Message word as the compression sees it; padding is applied on the fly.
  always_comb begin
    logic [5:0] bp;
    bp = '0;
    for (int k = 0; k < 4; k++) begin
      bp = {widx, 2'(k)};
      case (kind_q)
        K_NORMAL: mword[8*k +: 8] = blk_q[widx][k];
        K_PAD1: begin
          if (bp < pad_pos)       mword[8*k +: 8] = blk_q[widx][k];
          else if (bp == pad_pos) mword[8*k +: 8] = PadByte;
          else                    mword[8*k +: 8] = 8'h00;
        end
        default: mword[8*k +: 8] = 8'h00;
      endcase
    end
    if (kind_q == K_PAD2 || (kind_q == K_PAD1 && pad_pos < LenPos)) begin
      if (widx == 4'd14) mword = count_q[31:0];
      if (widx == 4'd15) mword = count_q[63:32];
    end
  end

  assign rsum  = fval + a_q + round_k(rnd_q) + mword;
  assign rot_w = {rsum, rsum} << rot_amt({rnd_q[5:4], rnd_q[1:0]});
  assign b_new = b_q + rot_w[63:32];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_NORMAL;
      fin_q       <= 1'b0;
      rnd_q       <= '0;
      count_q     <= '0;
      ha_q        <= InitA;
      hb_q        <= InitB;
      hc_q        <= InitC;
      hd_q        <= InitD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      fin_q   <= fin_d;
      if (state_q == S_ROUND) rnd_q <= rnd_q + 6'd1;
      if (accept && byte_valid_i) count_q <= count_q + 64'd8;
      if (state_q == S_ADD) begin
        ha_q <= sum_a;
        hb_q <= sum_b;
        hc_q <= sum_c;
        hd_q <= sum_d;
      end
      if (emit) begin
        ha_q    <= InitA;
        hb_q    <= InitB;
        hc_q    <= InitC;
        hd_q    <= InitD;
        count_q <= '0;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Working variables, output register and block store.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      a_q <= ha_q;
      b_q <= hb_q;
      c_q <= hc_q;
      d_q <= hd_q;
    end else if (state_q == S_ROUND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_new;
    end else if (state_q == S_ADD) begin
      a_q <= sum_a;
      b_q <= sum_b;
      c_q <= sum_c;
      d_q <= sum_d;
    end
    if (emit) begin
      out_a_q <= ha_q;
      out_b_q <= hb_q;
      out_c_q <= hc_q;
      out_d_q <= hd_q;
    end
    if (accept && byte_valid_i) blk_q[in_pos[5:2]][in_pos[1:0]] <= data_byte_i;
  end

`ifndef SYNTH
  a_rnd_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ROUND) |-> (rnd_q == 6'd0))
    else $error("round counter not at zero outside the round phase");

  a_emit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (count_q == 64'd0) && (state_q == S_IDLE) && out_valid_q)
    else $error("finish did not clear the count or load the output");

  a_pad2_need : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == K_PAD2) |-> (pad_pos >= LenPos))
    else $error("length block used although padding fitted in one block");
`endif

endmodule

`default_nettype wire
